// ----- rtl/core/sbpf_pkg.sv -----
// Shared types, constants and helpers for the servo-bus packet framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbpf_pkg;

    localparam int SBPF_QUEUE_DEPTH = 2;

    // Input tdata layout, lowest bit first
    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 16;
    localparam int OP_LSB   = 0;
    localparam int ID_LSB   = OP_LSB + OP_W;
    localparam int ADDR_LSB = ID_LSB + BYTE_W;
    localparam int CNT_LSB  = ADDR_LSB + BYTE_W;
    localparam int VAL_LSB  = CNT_LSB + BYTE_W;
    localparam int IN_BITS  = VAL_LSB + VALUE_W;
    localparam int S_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // Command operation codes
    localparam logic [OP_W-1:0] OP_PING  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    // Packet constants
    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] INSTR_PING  = 8'h01;
    localparam logic [7:0] INSTR_READ  = 8'h02;
    localparam logic [7:0] INSTR_WRITE = 8'h03;
    localparam logic [7:0] LEN_PING    = 8'd2;
    localparam logic [7:0] LEN_READ    = 8'd4;
    localparam logic [7:0] LEN_WRITE   = 8'd5;

    // Byte positions within a packet
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_HDR0   = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR1   = 4'd1;
    localparam logic [POS_W-1:0] POS_ID     = 4'd2;
    localparam logic [POS_W-1:0] POS_LEN    = 4'd3;
    localparam logic [POS_W-1:0] POS_INSTR  = 4'd4;
    localparam logic [POS_W-1:0] POS_ADDR   = 4'd5;
    localparam logic [POS_W-1:0] POS_P1     = 4'd6;
    localparam logic [POS_W-1:0] POS_P2     = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST_PING  = 4'd5;
    localparam logic [POS_W-1:0] POS_LAST_READ  = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST_WRITE = 4'd8;

    typedef enum logic [1:0] {
        KIND_PING,
        KIND_READ,
        KIND_WRITE
    } kind_t;

    // One classified command, ready to serialize
    typedef struct packed {
        kind_t      kind;
        logic [7:0] id;
        logic [7:0] addr;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] chk;
    } desc_t;

    function automatic logic [7:0] kind_len(input kind_t k);
        logic [7:0] r;
        case (k)
            KIND_PING:  r = LEN_PING;
            KIND_READ:  r = LEN_READ;
            KIND_WRITE: r = LEN_WRITE;
            default:    r = LEN_PING;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kind_instr(input kind_t k);
        logic [7:0] r;
        case (k)
            KIND_PING:  r = INSTR_PING;
            KIND_READ:  r = INSTR_READ;
            KIND_WRITE: r = INSTR_WRITE;
            default:    r = INSTR_PING;
        endcase
        return r;
    endfunction

    function automatic logic [POS_W-1:0] kind_last_pos(input kind_t k);
        logic [POS_W-1:0] r;
        case (k)
            KIND_PING:  r = POS_LAST_PING;
            KIND_READ:  r = POS_LAST_READ;
            KIND_WRITE: r = POS_LAST_WRITE;
            default:    r = POS_LAST_PING;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/servo_bus_packet_framer.sv -----
// Top level of the servo-bus instruction packet framer.
// Depends on sbpf_pkg, sbpf_front, sbpf_queue and sbpf_back.
//
//   Channel  Dir  Payload                                        Marker
//   s_*      in   operation, servo_id, reg_address, read_count,  -
//                 write_value (48-bit tdata)
//   m_*      out  out_byte (8-bit tdata)                         tlast = last_byte
//
// A command becomes 6 (ping), 8 (read) or 9 (write) output transactions, one byte
// per cycle while m_tready is high; the output byte register sets that rate and
// packets follow each other with no gap. The descriptor queue takes new commands
// while a packet drains. Unknown operation codes are accepted and produce nothing.
// Reset clears queue pointers, byte position and output valid; it takes effect at once.
// A stall on m_tready holds the current byte; s_tready drops only when the queue is full.
`timescale 1ns / 1ps

module servo_bus_packet_framer #(
    parameter int QUEUE_DEPTH = sbpf_pkg::SBPF_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] operation, [9:2] servo_id, [17:10] reg_address,
    // [25:18] read_count, [41:26] write_value, [47:42] zero
    input  logic [sbpf_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] out_byte
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast
);
    import sbpf_pkg::*;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_not_empty;
    desc_t push_desc;
    desc_t head_desc;

    sbpf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc)
    );

    sbpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    sbpf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (head_desc),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- rtl/core/sbpf_front.sv -----
// Front end of the framer: accepts commands, classifies them and builds descriptors.
// Depends on sbpf_pkg.
`timescale 1ns / 1ps

module sbpf_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sbpf_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         q_full,
    output logic                         q_push,
    output sbpf_pkg::desc_t              q_desc
);
    import sbpf_pkg::*;

    logic [OP_W-1:0]    op;
    logic [7:0]         id;
    logic [7:0]         addr;
    logic [7:0]         cnt;
    logic [VALUE_W-1:0] val;
    logic               known;
    kind_t              kind;
    logic [7:0]         p_addr;
    logic [7:0]         p1;
    logic [7:0]         p2;
    logic [7:0]         sum;

    assign op   = s_tdata[OP_LSB +: OP_W];
    assign id   = s_tdata[ID_LSB +: BYTE_W];
    assign addr = s_tdata[ADDR_LSB +: BYTE_W];
    assign cnt  = s_tdata[CNT_LSB +: BYTE_W];
    assign val  = s_tdata[VAL_LSB +: VALUE_W];

    always_comb
    begin
        known  = 1'b1;
        kind   = KIND_PING;
        p_addr = 8'd0;
        p1     = 8'd0;
        p2     = 8'd0;
        case (op)
            OP_PING:
            begin
                kind = KIND_PING;
            end
            OP_READ:
            begin
                kind   = KIND_READ;
                p_addr = addr;
                p1     = cnt;
            end
            OP_WRITE:
            begin
                kind   = KIND_WRITE;
                p_addr = addr;
                p1     = val[7:0];
                p2     = val[15:8];
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Unused parameters are zero, so one sum serves every kind
    assign sum = id + kind_len(kind) + kind_instr(kind) + p_addr + p1 + p2;

    // Drop unknown operations: accepted, never queued
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && known;

    assign q_desc.kind = kind;
    assign q_desc.id   = id;
    assign q_desc.addr = p_addr;
    assign q_desc.p1   = p1;
    assign q_desc.p2   = p2;
    assign q_desc.chk  = ~sum;

endmodule

// ----- rtl/core/sbpf_queue.sv -----
// Short descriptor queue between the front end and the serializer.
// Depends on sbpf_pkg for the descriptor type.
`timescale 1ns / 1ps

module sbpf_queue #(
    parameter int DEPTH = sbpf_pkg::SBPF_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sbpf_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output sbpf_pkg::desc_t head_desc
);
    import sbpf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    desc_t         mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_desc = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- rtl/core/sbpf_back.sv -----
// Back end: walks the head descriptor, drives one packet byte per cycle unless stalled.
// Depends on sbpf_pkg.
`timescale 1ns / 1ps

module sbpf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  sbpf_pkg::desc_t q_head,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);
    import sbpf_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             valid_reg, valid_next;
    logic [7:0]       data_reg;
    logic             last_reg;
    logic             load;
    logic             at_last;
    logic [7:0]       cur_byte;

    // A descriptor is queued and the output register is free or being drained this cycle
    assign load    = q_not_empty && (!valid_reg || m_tready);
    assign at_last = (pos_reg == kind_last_pos(q_head.kind));
    assign q_pop   = load && at_last;

    always_comb
    begin
        case (pos_reg) inside
            POS_HDR0, POS_HDR1: cur_byte = HDR_BYTE;
            POS_ID:             cur_byte = q_head.id;
            POS_LEN:            cur_byte = kind_len(q_head.kind);
            POS_INSTR:          cur_byte = kind_instr(q_head.kind);
            POS_ADDR:           cur_byte = q_head.addr;
            POS_P1:             cur_byte = q_head.p1;
            POS_P2:             cur_byte = q_head.p2;
            default:            cur_byte = HDR_BYTE;
        endcase
        if (at_last)
        begin
            cur_byte = q_head.chk;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = at_last ? '0 : pos_reg + 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= cur_byte;
            last_reg <= at_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- rtl/core/sbpf_checker.sv -----
// Port-level checker for the servo-bus packet framer, bound to the top level.
// Depends on sbpf_pkg for packet constants.
`timescale 1ns / 1ps

module sbpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import sbpf_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic             xfer;

    assign xfer = m_tvalid && m_tready;

    // Track byte position and running sum of each packet as seen on the port
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (xfer)
        begin
            if (m_tlast)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg >= POS_ID)
                begin
                    sum_next = sum_reg + m_tdata;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output byte changed under stall");

    a_header: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && (pos_reg == POS_HDR0 || pos_reg == POS_HDR1) |->
            m_tdata == HDR_BYTE && !m_tlast)
        else $error("packet header byte wrong");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && m_tlast |->
            pos_reg == POS_LAST_PING || pos_reg == POS_LAST_READ
            || pos_reg == POS_LAST_WRITE)
        else $error("packet ended at an illegal length");

    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && pos_reg == POS_LAST_WRITE |-> m_tlast)
        else $error("packet ran past its longest form");

    a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && m_tlast |-> m_tdata == ~sum_reg)
        else $error("packet checksum mismatch");

endmodule

bind servo_bus_packet_framer sbpf_checker u_sbpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
